// ===== rtl/core/software_timer_bank_assert.svh =====
// ----------------------------------------------------------------------------
// software_timer_bank_assert.svh
// assertion macros shared by the timer bank rtl
// ----------------------------------------------------------------------------
`ifndef SOFTWARE_TIMER_BANK_ASSERT_SVH
`define SOFTWARE_TIMER_BANK_ASSERT_SVH

// same-cycle implication, held off during reset
`define STB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("software_timer_bank: same-cycle check failed");

// next-cycle implication, held off during reset
`define STB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("software_timer_bank: next-cycle check failed");

`endif

// ===== rtl/core/stb_pkg.sv =====
// ----------------------------------------------------------------------------
// stb_pkg
// types and codes shared by the timer bank controller, datapath and top level
// ----------------------------------------------------------------------------
package stb_pkg;

  // command codes
  localparam logic [2:0] FUNC_REGISTER = 3'd0;
  localparam logic [2:0] FUNC_START    = 3'd1;
  localparam logic [2:0] FUNC_MODIFY   = 3'd2;
  localparam logic [2:0] FUNC_STOP     = 3'd3;
  localparam logic [2:0] FUNC_DELETE   = 3'd4;
  localparam logic [2:0] FUNC_DEL_ALL  = 3'd5;
  localparam logic [2:0] FUNC_TICK     = 3'd6;

  // result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_FIRE   = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  // status codes
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_FOUND = 1'b1;

  typedef struct packed {
    logic [2:0]  func;
    logic [3:0]  slot;
    logic [31:0] timeout;
    logic        one_shot;
    logic        has_callback;
    logic [31:0] now;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] fired_slot;
    logic       status;
    logic       last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;    // latch the accepted item
    logic cmd_exec;   // apply a slot command and post its status
    logic scan_rd;    // read timeout and stamp of the scanned slot
    logic scan_step;  // update the scanned slot, post a fire event if due, with a callback and not deleted
    logic emit_done;  // post the tick done result
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_is_tick; // item on the input channel is a tick
    logic fire_emit;  // scanned slot needs a fire event
    logic out_free;   // output register can take a result this cycle
  } dp_sts_t;

endpackage

// ===== rtl/core/stb_ctrl.sv =====
// ----------------------------------------------------------------------------
// stb_ctrl
// sequencer for the timer bank: command execution and the tick scan
// ----------------------------------------------------------------------------
module stb_ctrl #(
  parameter int NUM_SLOTS = 16,
  localparam int SIW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  stb_pkg::dp_sts_t    sts,
  output stb_pkg::ctrl_cmd_t  cmd,
  output logic [SIW-1:0]      scan_idx
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CMD  = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_EVAL = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic [SIW-1:0] LAST_IDX = SIW'(NUM_SLOTS - 1);

  logic [2:0]     state_r, state_nxt;
  logic [SIW-1:0] idx_r, idx_nxt;

  assign in_ready = (state_r == ST_IDLE);
  assign scan_idx = idx_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          idx_nxt     = '0;
          state_nxt   = sts.in_is_tick ? ST_RD : ST_CMD;
        end
      end
      ST_CMD: begin
        if (sts.out_free) begin
          cmd.cmd_exec = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = ST_EVAL;
      end
      ST_EVAL: begin
        if (!sts.fire_emit || sts.out_free) begin
          cmd.scan_step = 1'b1;
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_DONE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_RD;
          end
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.emit_done = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// ===== rtl/core/stb_datapath.sv =====
// ----------------------------------------------------------------------------
// stb_datapath
// slot marks, timeout and stamp memories, expiry compare and result register
// ----------------------------------------------------------------------------
module stb_datapath #(
  parameter int NUM_SLOTS  = 16,
  parameter int TICK_WIDTH = 32,
  localparam int SIW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  stb_pkg::in_item_t   in_data,
  input  logic                out_ready,
  output logic                out_valid,
  output stb_pkg::out_item_t  out_data,
  input  stb_pkg::ctrl_cmd_t  cmd,
  input  logic [SIW-1:0]      scan_idx,
  output stb_pkg::dp_sts_t    sts
);

  // captured item
  logic [2:0]            func_r;
  logic [3:0]            slot_r;
  logic [TICK_WIDTH-1:0] tmo_r;
  logic                  os_r;
  logic                  cb_r;
  logic [TICK_WIDTH-1:0] now_r;

  // slot marks
  logic [NUM_SLOTS-1:0] listed_r, listed_nxt;
  logic [NUM_SLOTS-1:0] running_r, running_nxt;
  logic [NUM_SLOTS-1:0] retired_r, retired_nxt;
  logic [NUM_SLOTS-1:0] single_r, single_nxt;
  logic [NUM_SLOTS-1:0] cbk_r, cbk_nxt;

  // timeout and stamp memories
  logic [TICK_WIDTH-1:0] period_mem [NUM_SLOTS];
  logic [TICK_WIDTH-1:0] stamp_mem  [NUM_SLOTS];
  logic [TICK_WIDTH-1:0] per_rd_r;
  logic [TICK_WIDTH-1:0] stp_rd_r;

  logic                  out_valid_r;
  stb_pkg::out_item_t    out_data_r;

  logic [SIW-1:0]        slot_idx;
  logic                  inbank;
  logic                  found;
  logic                  status_bit;
  logic                  per_we;
  logic                  stp_we;
  logic [SIW-1:0]        stp_waddr;
  logic [TICK_WIDTH-1:0] elapsed;
  logic                  due;
  logic                  emit;
  logic                  run_after;

  assign slot_idx = SIW'(slot_r);
  assign inbank   = (32'(slot_r) < NUM_SLOTS);
  assign found    = inbank && listed_r[slot_idx];

  // expiry check of the scanned slot, wraps modulo the tick width
  assign elapsed   = now_r - stp_rd_r;
  assign due       = listed_r[scan_idx] && running_r[scan_idx] && (elapsed >= per_rd_r);
  assign emit      = due && cbk_r[scan_idx] && !retired_r[scan_idx];
  assign run_after = running_r[scan_idx] && !(due && single_r[scan_idx]);

  assign sts.in_is_tick = (in_data.func == stb_pkg::FUNC_TICK);
  assign sts.fire_emit  = emit;
  assign sts.out_free   = !out_valid_r || out_ready;

  always_comb begin
    listed_nxt  = listed_r;
    running_nxt = running_r;
    retired_nxt = retired_r;
    single_nxt  = single_r;
    cbk_nxt     = cbk_r;
    status_bit  = stb_pkg::STATUS_NOT_FOUND;
    per_we      = 1'b0;
    stp_we      = 1'b0;
    stp_waddr   = scan_idx;
    if (cmd.cmd_exec) begin
      stp_waddr = slot_idx;
      case (func_r)
        stb_pkg::FUNC_REGISTER: begin
          if (inbank) begin
            listed_nxt[slot_idx]  = 1'b1;
            running_nxt[slot_idx] = 1'b0;
            retired_nxt[slot_idx] = 1'b0;
            single_nxt[slot_idx]  = os_r;
            cbk_nxt[slot_idx]     = cb_r;
            per_we                = 1'b1;
            status_bit            = stb_pkg::STATUS_OK;
          end
        end
        stb_pkg::FUNC_START, stb_pkg::FUNC_MODIFY: begin
          if (found) begin
            running_nxt[slot_idx] = 1'b1;
            stp_we                = 1'b1;
            per_we                = (func_r == stb_pkg::FUNC_MODIFY);
            status_bit            = stb_pkg::STATUS_OK;
          end
        end
        stb_pkg::FUNC_STOP, stb_pkg::FUNC_DELETE: begin
          if (found) begin
            running_nxt[slot_idx] = 1'b0;
            if (func_r == stb_pkg::FUNC_DELETE) begin
              retired_nxt[slot_idx] = 1'b1;
            end
            status_bit = stb_pkg::STATUS_OK;
          end
        end
        stb_pkg::FUNC_DEL_ALL: begin
          running_nxt = running_r & ~listed_r;
          retired_nxt = retired_r | listed_r;
          status_bit  = stb_pkg::STATUS_OK;
        end
        default: begin
          status_bit = stb_pkg::STATUS_NOT_FOUND;
        end
      endcase
    end else if (cmd.scan_step && listed_r[scan_idx]) begin
      running_nxt[scan_idx] = run_after;
      stp_we                = due;
      if (!run_after && (single_r[scan_idx] || retired_r[scan_idx])) begin
        listed_nxt[scan_idx] = 1'b0;
      end
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_data.func;
      slot_r <= in_data.slot;
      tmo_r  <= TICK_WIDTH'(in_data.timeout);
      os_r   <= in_data.one_shot;
      cb_r   <= in_data.has_callback;
      now_r  <= TICK_WIDTH'(in_data.now);
    end
  end

  // marks with a defined reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listed_r  <= '0;
      running_r <= '0;
    end else begin
      listed_r  <= listed_nxt;
      running_r <= running_nxt;
    end
  end

  // marks written before use
  always_ff @(posedge clk) begin
    retired_r <= retired_nxt;
    single_r  <= single_nxt;
    cbk_r     <= cbk_nxt;
  end

  // memories: one write port each, registered read at the scan index
  always_ff @(posedge clk) begin
    if (per_we) begin
      period_mem[slot_idx] <= tmo_r;
    end
    if (stp_we) begin
      stamp_mem[stp_waddr] <= now_r;
    end
    if (cmd.scan_rd) begin
      per_rd_r <= period_mem[scan_idx];
      stp_rd_r <= stamp_mem[scan_idx];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.cmd_exec || (cmd.scan_step && emit) || cmd.emit_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmd_exec) begin
      out_data_r.kind       <= stb_pkg::KIND_STATUS;
      out_data_r.fired_slot <= slot_r;
      out_data_r.status     <= status_bit;
      out_data_r.last       <= 1'b1;
    end else if (cmd.scan_step && emit) begin
      out_data_r.kind       <= stb_pkg::KIND_FIRE;
      out_data_r.fired_slot <= 4'(scan_idx);
      out_data_r.status     <= stb_pkg::STATUS_OK;
      out_data_r.last       <= 1'b0;
    end else if (cmd.emit_done) begin
      out_data_r.kind       <= stb_pkg::KIND_DONE;
      out_data_r.fired_slot <= '0;
      out_data_r.status     <= stb_pkg::STATUS_OK;
      out_data_r.last       <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/software_timer_bank.sv =====
// ----------------------------------------------------------------------------
// software_timer_bank
// bank of timer slots driven by commands, with a scanning tick
// ----------------------------------------------------------------------------
//
//   channel  | ports                      | moves
//   ---------+----------------------------+--------------------------------
//   input    | in_valid in_ready in_data  | one command per transfer
//   result   | out_valid out_ready out_data | status, fire and done results
//
// - a slot command is captured, then executed and its status posted
// - a tick is captured, then each slot gets a read and a compare step through
//   the single read port of the timeout and stamp memories, then the done
//   result is posted
// - reset (rst_n low, synchronous) unlists and stops every slot; no clearing
//   pass is needed as the memories are always written before their contents are used
// - a full result register stalls the sequencer only when it has a result to
//   post; a new command is taken while the last result still waits
//
`include "software_timer_bank_assert.svh"

module software_timer_bank #(
  parameter int NUM_SLOTS  = 16,
  parameter int TICK_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  stb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output stb_pkg::out_item_t out_data
);

  localparam int SIW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // sequencer commands and datapath status
  stb_pkg::ctrl_cmd_t cmd;
  stb_pkg::dp_sts_t   sts;
  logic [SIW-1:0]     scan_idx;

  // controller: walks the command and scan sequence
  stb_ctrl #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd),
    .scan_idx (scan_idx)
  );

  // datapath: slot storage, expiry compare and result register
  stb_datapath #(
    .NUM_SLOTS  (NUM_SLOTS),
    .TICK_WIDTH (TICK_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .scan_idx  (scan_idx),
    .sts       (sts)
  );

  // the sequencer issues at most one step per cycle
  `STB_ASSERT_NOW(a_one_step, clk, rst_n, 1'b1, $onehot0(cmd))
  // an accepted transfer takes the sequencer out of idle
  `STB_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  // a fire event is never posted over a result still waiting
  `STB_ASSERT_NOW(a_fire_no_overwrite, clk, rst_n, cmd.scan_step && sts.fire_emit,
                  sts.out_free)
  // done and status results only go into a free result register
  `STB_ASSERT_NOW(a_post_free, clk, rst_n, cmd.emit_done || cmd.cmd_exec, sts.out_free)

endmodule
